FILE: rtl/core/dtp_pkg.sv
// Shared types, constants and field tables for the date/time text parser.
`default_nettype none

package dtp_pkg;

   typedef enum logic [6:0] {
      FLD_YEAR   = 7'b0000001,
      FLD_MONTH  = 7'b0000010,
      FLD_DAY    = 7'b0000100,
      FLD_HOUR   = 7'b0001000,
      FLD_MINUTE = 7'b0010000,
      FLD_SECOND = 7'b0100000,
      FLD_MSEC   = 7'b1000000
   } field_type;

   localparam int unsigned ACC_W   = 14;
   localparam int unsigned COUNT_W = 3;
   localparam int unsigned VALUE_W = 12;

   localparam logic [7:0] CH_NUL  = 8'h00;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   localparam logic [ACC_W-1:0] YEAR_SHORT_LIMIT = 14'd100;
   localparam logic [ACC_W-1:0] YEAR_BASE        = 14'd2000;

   typedef struct packed {
      logic               ok;
      logic [VALUE_W-1:0] value;
   } close_type;

   function automatic logic [COUNT_W-1:0] min_digits(input field_type f);
      logic [COUNT_W-1:0] r;
      case (f)
         FLD_YEAR: r = 3'd2;
         default:  r = 3'd1;
      endcase
      return r;
   endfunction

   function automatic logic [COUNT_W-1:0] max_digits(input field_type f);
      logic [COUNT_W-1:0] r;
      case (f)
         FLD_YEAR:   r = 3'd4;
         FLD_MONTH:  r = 3'd2;
         FLD_DAY:    r = 3'd2;
         FLD_HOUR:   r = 3'd2;
         FLD_MINUTE: r = 3'd2;
         FLD_SECOND: r = 3'd2;
         FLD_MSEC:   r = 3'd3;
         default:    r = 3'd0;
      endcase
      return r;
   endfunction

   function automatic logic [ACC_W-1:0] low_value(input field_type f);
      logic [ACC_W-1:0] r;
      case (f)
         FLD_YEAR:  r = 14'd1900;
         FLD_MONTH: r = 14'd1;
         FLD_DAY:   r = 14'd1;
         default:   r = 14'd0;
      endcase
      return r;
   endfunction

   function automatic logic [ACC_W-1:0] high_value(input field_type f);
      logic [ACC_W-1:0] r;
      case (f)
         FLD_YEAR:   r = 14'd2100;
         FLD_MONTH:  r = 14'd12;
         FLD_DAY:    r = 14'd31;
         FLD_HOUR:   r = 14'd23;
         FLD_MINUTE: r = 14'd59;
         FLD_SECOND: r = 14'd59;
         FLD_MSEC:   r = 14'd999;
         default:    r = 14'd0;
      endcase
      return r;
   endfunction

   function automatic field_type next_field(input field_type f);
      field_type r;
      case (f)
         FLD_YEAR:   r = FLD_MONTH;
         FLD_MONTH:  r = FLD_DAY;
         FLD_DAY:    r = FLD_HOUR;
         FLD_HOUR:   r = FLD_MINUTE;
         FLD_MINUTE: r = FLD_SECOND;
         FLD_SECOND: r = FLD_MSEC;
         default:    r = FLD_MSEC;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/date_time_text_parser_unit.sv
// Top level of the date/time text parser: character stream in, one date word per string.
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid, req_stall | req_ch (8 bits, 0 ends the string)
//   rsp_    | out       | rsp_valid, rsp_stall | rsp_ok, rsp_year .. rsp_millisecond
//
// One character is taken per cycle while req_stall is low; the field state updates in the same cycle.
// A terminator loads the result register, which shows the word from the next cycle on.
// Input stalls only while a result word is held and the output side stalls.
// Synchronous reset returns the parser to the year field and empties the result register.
`default_nettype none

module date_time_text_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_ok,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second,
   output logic [9:0]  rsp_millisecond
);

   dtp_pkg::field_type                field_ff, field_in;
   logic [dtp_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic [dtp_pkg::ACC_W-1:0]         acc_ff, acc_in;
   logic                              failed_ff, failed_in;
   logic [11:0]                       year_ff, year_in;
   logic [3:0]                        month_ff, month_in;
   logic [4:0]                        day_ff, day_in;
   logic [4:0]                        hour_ff, hour_in;
   logic [5:0]                        minute_ff, minute_in;
   logic [5:0]                        second_ff, second_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_ok_ff, rsp_ok_in;
   logic [11:0]                       rsp_year_ff, rsp_year_in;
   logic [3:0]                        rsp_month_ff, rsp_month_in;
   logic [4:0]                        rsp_day_ff, rsp_day_in;
   logic [4:0]                        rsp_hour_ff, rsp_hour_in;
   logic [5:0]                        rsp_minute_ff, rsp_minute_in;
   logic [5:0]                        rsp_second_ff, rsp_second_in;
   logic [9:0]                        rsp_msec_ff, rsp_msec_in;

   dtp_pkg::close_type                close;
   logic                              accept;
   logic                              is_term;
   logic                              is_digit;
   logic                              good;
   logic [dtp_pkg::ACC_W-1:0]         acc_x10;

   dtp_close u_close (
      .field  (field_ff),
      .count  (count_ff),
      .acc    (acc_ff),
      .result (close)
   );

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_term   = (req_ch == dtp_pkg::CH_NUL);
   assign acc_x10   = {acc_ff[dtp_pkg::ACC_W-4:0], 3'b000} +
                      {acc_ff[dtp_pkg::ACC_W-2:0], 1'b0};

   always_comb begin
      is_digit = req_ch inside {[dtp_pkg::CH_ZERO:dtp_pkg::CH_NINE]};
      good     = !failed_ff && close.ok &&
                 (field_ff inside {dtp_pkg::FLD_DAY, dtp_pkg::FLD_MINUTE,
                                   dtp_pkg::FLD_SECOND, dtp_pkg::FLD_MSEC});
   end

   // field state
   always_comb begin
      field_in  = field_ff;
      count_in  = count_ff;
      acc_in    = acc_ff;
      failed_in = failed_ff;
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      if (accept) begin
         if (is_term) begin
            field_in  = dtp_pkg::FLD_YEAR;
            count_in  = '0;
            acc_in    = '0;
            failed_in = 1'b0;
            year_in   = '0;
            month_in  = '0;
            day_in    = '0;
            hour_in   = '0;
            minute_in = '0;
            second_in = '0;
         end else if (!failed_ff) begin
            if (is_digit) begin
               if (count_ff >= dtp_pkg::max_digits(field_ff)) begin
                  failed_in = 1'b1;
               end else begin
                  count_in = count_ff + 3'd1;
                  acc_in   = acc_x10 + {{(dtp_pkg::ACC_W-4){1'b0}}, req_ch[3:0]};
               end
            end else if (!close.ok || field_ff == dtp_pkg::FLD_MSEC) begin
               failed_in = 1'b1;
            end else begin
               case (field_ff)
                  dtp_pkg::FLD_YEAR:   year_in   = close.value;
                  dtp_pkg::FLD_MONTH:  month_in  = close.value[3:0];
                  dtp_pkg::FLD_DAY:    day_in    = close.value[4:0];
                  dtp_pkg::FLD_HOUR:   hour_in   = close.value[4:0];
                  dtp_pkg::FLD_MINUTE: minute_in = close.value[5:0];
                  dtp_pkg::FLD_SECOND: second_in = close.value[5:0];
                  default:             failed_in = 1'b1;
               endcase
               field_in = dtp_pkg::next_field(field_ff);
               count_in = '0;
               acc_in   = '0;
            end
         end
      end
   end

   // result word, with the current field closed in
   always_comb begin
      rsp_ok_in     = good;
      rsp_year_in   = '0;
      rsp_month_in  = '0;
      rsp_day_in    = '0;
      rsp_hour_in   = '0;
      rsp_minute_in = '0;
      rsp_second_in = '0;
      rsp_msec_in   = '0;
      if (good) begin
         rsp_year_in   = year_ff;
         rsp_month_in  = month_ff;
         rsp_day_in    = (field_ff == dtp_pkg::FLD_DAY) ? close.value[4:0] : day_ff;
         rsp_hour_in   = hour_ff;
         rsp_minute_in = (field_ff == dtp_pkg::FLD_MINUTE) ? close.value[5:0] : minute_ff;
         rsp_second_in = (field_ff == dtp_pkg::FLD_SECOND) ? close.value[5:0] : second_ff;
         rsp_msec_in   = (field_ff == dtp_pkg::FLD_MSEC) ? close.value[9:0] : 10'd0;
      end
      if (accept && is_term) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_ff     <= dtp_pkg::FLD_YEAR;
         count_ff     <= '0;
         acc_ff       <= '0;
         failed_ff    <= 1'b0;
         year_ff      <= '0;
         month_ff     <= '0;
         day_ff       <= '0;
         hour_ff      <= '0;
         minute_ff    <= '0;
         second_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         field_ff     <= field_in;
         count_ff     <= count_in;
         acc_ff       <= acc_in;
         failed_ff    <= failed_in;
         year_ff      <= year_in;
         month_ff     <= month_in;
         day_ff       <= day_in;
         hour_ff      <= hour_in;
         minute_ff    <= minute_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_term) begin
         rsp_ok_ff     <= rsp_ok_in;
         rsp_year_ff   <= rsp_year_in;
         rsp_month_ff  <= rsp_month_in;
         rsp_day_ff    <= rsp_day_in;
         rsp_hour_ff   <= rsp_hour_in;
         rsp_minute_ff <= rsp_minute_in;
         rsp_second_ff <= rsp_second_in;
         rsp_msec_ff   <= rsp_msec_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_year        = rsp_year_ff;
   assign rsp_month       = rsp_month_ff;
   assign rsp_day         = rsp_day_ff;
   assign rsp_hour        = rsp_hour_ff;
   assign rsp_minute      = rsp_minute_ff;
   assign rsp_second      = rsp_second_ff;
   assign rsp_millisecond = rsp_msec_ff;

   a_term_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && is_term |=> field_ff == dtp_pkg::FLD_YEAR && count_ff == '0 &&
                            acc_ff == '0 && !failed_ff)
      else $error("parser state not cleared after terminator");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= dtp_pkg::max_digits(field_ff))
      else $error("digit count beyond field maximum");

   a_failed_holds: assert property (@(posedge clock) disable iff (reset)
      failed_ff && !(accept && is_term) |=> failed_ff && $stable(field_ff) &&
                                            $stable(acc_ff))
      else $error("state moved after failure");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> rsp_year_ff == '0 && rsp_month_ff == '0 &&
         rsp_day_ff == '0 && rsp_hour_ff == '0 && rsp_minute_ff == '0 &&
         rsp_second_ff == '0 && rsp_msec_ff == '0)
      else $error("failed word carries nonzero fields");

   a_ok_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ok_ff |-> rsp_year_ff >= 12'd1900 && rsp_year_ff <= 12'd2100 &&
         rsp_month_ff >= 4'd1 && rsp_month_ff <= 4'd12 && rsp_day_ff >= 5'd1)
      else $error("good word out of range");

endmodule

`default_nettype wire

FILE: rtl/core/dtp_close.sv
// Field close check: digit count, short-year offset and value range.
`default_nettype none

module dtp_close (
   input  dtp_pkg::field_type                 field,
   input  logic [dtp_pkg::COUNT_W-1:0]        count,
   input  logic [dtp_pkg::ACC_W-1:0]          acc,
   output dtp_pkg::close_type                 result
);

   logic [dtp_pkg::ACC_W-1:0] adj;
   logic                      count_ok;
   logic                      range_ok;

   always_comb begin
      if (field == dtp_pkg::FLD_YEAR && acc < dtp_pkg::YEAR_SHORT_LIMIT) begin
         adj = acc + dtp_pkg::YEAR_BASE;
      end else begin
         adj = acc;
      end
      count_ok = (count >= dtp_pkg::min_digits(field)) &&
                 (count <= dtp_pkg::max_digits(field));
      range_ok = (adj >= dtp_pkg::low_value(field)) &&
                 (adj <= dtp_pkg::high_value(field));
      result.ok    = count_ok && range_ok;
      result.value = adj[dtp_pkg::VALUE_W-1:0];
   end

endmodule

`default_nettype wire
